### hw/rtl/falru_pkg.sv
// shared types, constants and helpers for the fully associative lru cache
`default_nettype none

package falru_pkg;

    localparam int LINES     = 8;
    localparam int KEY_BITS  = 64;
    localparam int IDX_W     = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int KEY_W     = 64;
    localparam int DATA_W    = 64;
    localparam int OUT_IDX_W = 3;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [KEY_BITS-1:0]  key_t;
    typedef logic [DATA_W-1:0]    data_t;
    typedef logic [OUT_IDX_W-1:0] out_idx_t;

    typedef enum logic {
        REQ_LOOKUP = 1'b0,
        REQ_INSERT = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic load_req;
        logic do_match;
        logic do_update;
    } dp_cmd_t;

    typedef struct packed {
        logic out_stall;
    } dp_status_t;

    function automatic out_idx_t to_out_idx(input idx_t idx);
        logic [IDX_W+OUT_IDX_W-1:0] wide;
        wide = {{OUT_IDX_W{1'b0}}, idx};
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/falru_if.sv
// request and response channel interfaces
`default_nettype none

interface falru_req_if
    import falru_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [KEY_W-1:0]    key;
    logic [DATA_W-1:0]   data_in;

    modport source (output valid, output req_type, output key, output data_in, input ready);
    modport sink   (input valid, input req_type, input key, input data_in, output ready);
endinterface

interface falru_rsp_if
    import falru_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [OUT_IDX_W-1:0] line_index;
    logic [DATA_W-1:0]    data_out;
    logic                 victim_was_valid;

    modport source (output valid, output hit, output line_index, output data_out,
                    output victim_was_valid, input ready);
    modport sink   (input valid, input hit, input line_index, input data_out,
                    input victim_was_valid, output ready);
endinterface

`default_nettype wire

### hw/rtl/falru_ctrl.sv
// controller state machine sequencing compare and recency update
`default_nettype none

module falru_ctrl
    import falru_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    output dp_cmd_t         cmd,
    input  wire dp_status_t status
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!status.out_stall)
                begin
                    state_next = req_valid ? ST_MATCH : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready     = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.load_req = req_valid;
            end
            ST_MATCH:
            begin
                cmd.do_match = 1'b1;
            end
            ST_UPDATE:
            begin
                if (!status.out_stall)
                begin
                    cmd.do_update = 1'b1;
                    req_ready     = 1'b1;
                    cmd.load_req  = req_valid;
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTH
    // compare is always followed by the update step
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MATCH |=> state_reg == ST_UPDATE)
        else $error("compare not followed by update");

    // an accepted item goes to the compare step next
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_req |=> state_reg == ST_MATCH)
        else $error("accepted item did not enter compare");
`endif

endmodule

`default_nettype wire

### hw/rtl/falru_dp.sv
// datapath: line storage, key compare, recency list and output register
`default_nettype none

module falru_dp
    import falru_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    output dp_status_t             status,
    input  wire logic              req_type,
    input  wire logic [KEY_W-1:0]  key,
    input  wire data_t             data_in,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output logic                   hit,
    output out_idx_t               line_index,
    output data_t                  data_out,
    output logic                   victim_was_valid
);

    logic  line_valid_reg [LINES];
    key_t  line_key_reg   [LINES];
    data_t line_data_reg  [LINES];
    idx_t  order_reg      [LINES];
    idx_t  order_next     [LINES];

    logic  req_insert_reg;
    key_t  req_key_reg;
    data_t req_data_reg;

    logic  hit_reg;
    idx_t  idx_reg;
    data_t data_reg;
    logic  vwv_reg;

    logic     rsp_valid_reg;
    logic     rsp_valid_next;
    logic     out_hit_reg;
    out_idx_t out_idx_reg;
    data_t    out_data_reg;
    logic     out_vwv_reg;

    logic [LINES-1:0] match_vec;
    logic             match_any;
    idx_t             match_idx;
    idx_t             victim;

    logic [LINES-1:0] pos_eq;
    logic [LINES-1:0] pos_prefix;
    logic             move_en;

    assign status.out_stall = rsp_valid_reg && !rsp_ready;

    // parallel compare against every line, lowest match wins
    always_comb
    begin
        match_idx = '0;
        for (int i = 0; i < LINES; i++)
        begin
            match_vec[i] = line_valid_reg[i] && (line_key_reg[i] == req_key_reg);
        end
        for (int i = LINES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                match_idx = idx_t'(i);
            end
        end
        match_any = |match_vec;
        victim    = order_reg[LINES-1];
    end

    // move-to-front of the chosen line
    assign move_en = req_insert_reg || hit_reg;

    always_comb
    begin
        for (int i = 0; i < LINES; i++)
        begin
            pos_eq[i] = (order_reg[i] == idx_reg);
        end
        pos_prefix[0] = pos_eq[0];
        for (int i = 1; i < LINES; i++)
        begin
            pos_prefix[i] = pos_prefix[i-1] || pos_eq[i];
        end
        order_next[0] = idx_reg;
        for (int i = 1; i < LINES; i++)
        begin
            if (!pos_prefix[i-1])
            begin
                order_next[i] = order_reg[i-1];
            end
            else
            begin
                order_next[i] = order_reg[i];
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.do_update)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < LINES; i++)
            begin
                line_valid_reg[i] <= 1'b0;
                order_reg[i]      <= idx_t'(i);
            end
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (cmd.do_update)
            begin
                if (req_insert_reg)
                begin
                    line_valid_reg[idx_reg] <= 1'b1;
                end
                if (move_en)
                begin
                    for (int i = 0; i < LINES; i++)
                    begin
                        order_reg[i] <= order_next[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_insert_reg <= (req_type == REQ_INSERT);
            req_key_reg    <= key[KEY_BITS-1:0];
            req_data_reg   <= data_in;
        end
        if (cmd.do_match)
        begin
            if (req_insert_reg)
            begin
                hit_reg  <= 1'b0;
                idx_reg  <= victim;
                data_reg <= '0;
                vwv_reg  <= line_valid_reg[victim];
            end
            else
            begin
                hit_reg  <= match_any;
                idx_reg  <= match_idx;
                data_reg <= match_any ? line_data_reg[match_idx] : '0;
                vwv_reg  <= 1'b0;
            end
        end
        if (cmd.do_update)
        begin
            if (req_insert_reg)
            begin
                line_key_reg[idx_reg]  <= req_key_reg;
                line_data_reg[idx_reg] <= req_data_reg;
            end
            out_hit_reg  <= hit_reg;
            out_idx_reg  <= to_out_idx(idx_reg);
            out_data_reg <= data_reg;
            out_vwv_reg  <= vwv_reg;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign hit              = out_hit_reg;
    assign line_index       = out_idx_reg;
    assign data_out         = out_data_reg;
    assign victim_was_valid = out_vwv_reg;

`ifndef SYNTH
    // inserted line is valid afterwards
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_update && req_insert_reg |=> line_valid_reg[$past(idx_reg)])
        else $error("inserted line not marked valid");

    // a used line sits at the front of the recency list
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_update && move_en |=> order_reg[0] == $past(idx_reg))
        else $error("used line not moved to front");

    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        status.out_stall |-> !cmd.do_update)
        else $error("result overwritten while stalled");

    // hit and victim flag never together
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(out_hit_reg && out_vwv_reg))
        else $error("hit and victim flag both set");
`endif

endmodule

`default_nettype wire

### hw/rtl/fully_associative_lru_cache.sv
// top level of the fully associative lru cache
`default_nettype none

// Fully associative cache of LINES lines with least recently used replacement.
// A lookup compares the key with every valid line at once and on the lowest
// matching line returns hit, line index and data word, moving that line to the
// front of the recency list. An insert overwrites the line at the back of the
// list without a duplicate check and reports the victim index and whether it
// held valid data. Each item goes through a key compare step and then a
// recency list shift step, which the next item must see. A result waits in
// an output register, and the next item is taken while it waits; only the
// update step holds when the output register is still full. The state is ready
// right after reset, with no clearing pass.
module fully_associative_lru_cache
    import falru_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    falru_req_if.sink   req,
    falru_rsp_if.source rsp
);

    dp_cmd_t    cmd;
    dp_status_t status;

    falru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .cmd       (cmd),
        .status    (status)
    );

    falru_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .req_type         (req.req_type),
        .key              (req.key),
        .data_in          (req.data_in),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .hit              (rsp.hit),
        .line_index       (rsp.line_index),
        .data_out         (rsp.data_out),
        .victim_was_valid (rsp.victim_was_valid)
    );

endmodule

`default_nettype wire

### bench/tb.sv
// self-checking testbench for the fully associative lru cache
`timescale 1ns / 1ps

module tb;
    import falru_pkg::*;

    localparam int STALL_LIMIT = 3000;

    typedef struct {
        logic     hit;
        out_idx_t line_index;
        data_t    data_out;
        logic     victim_was_valid;
    } cache_rsp_t;

    class lru_cache_scoreboard;
        bit         line_valid [LINES];
        key_t       line_key [LINES];
        data_t      line_data [LINES];
        idx_t       recency [LINES];
        cache_rsp_t owed_rsp [$];
        int         err_count;

        function new();
            err_count = 0;
            for (int i = 0; i < LINES; i++)
            begin
                line_valid[i] = 1'b0;
                line_key[i]   = '0;
                line_data[i]  = '0;
                recency[i]    = idx_t'(i);
            end
        endfunction

        function int pending();
            return owed_rsp.size();
        endfunction

        function void move_to_front(idx_t line);
            int pos;
            pos = LINES - 1;
            for (int i = LINES - 1; i >= 0; i--)
                if (recency[i] == line)
                    pos = i;
            for (int i = pos; i > 0; i--)
                recency[i] = recency[i-1];
            recency[0] = line;
        endfunction

        function void note_request(req_type_t kind, key_t k, data_t d);
            cache_rsp_t exp_rsp;
            idx_t       victim;
            exp_rsp = '{hit: 1'b0, line_index: '0, data_out: '0, victim_was_valid: 1'b0};
            if (kind == REQ_LOOKUP)
            begin
                for (int i = 0; i < LINES; i++)
                begin
                    if (!exp_rsp.hit && line_valid[i] && line_key[i] == k)
                    begin
                        exp_rsp.hit        = 1'b1;
                        exp_rsp.line_index = out_idx_t'(i);
                        exp_rsp.data_out   = line_data[i];
                        move_to_front(idx_t'(i));
                    end
                end
            end
            else
            begin
                victim                   = recency[LINES-1];
                exp_rsp.victim_was_valid = line_valid[victim];
                exp_rsp.line_index       = out_idx_t'(victim);
                line_key[victim]         = k;
                line_data[victim]        = d;
                line_valid[victim]       = 1'b1;
                move_to_front(victim);
            end
            owed_rsp.push_back(exp_rsp);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            err_count++;
        endtask

        task check_response(logic hit, out_idx_t idx, data_t d, logic vwv);
            cache_rsp_t exp_rsp;
            if (owed_rsp.size() == 0)
            begin
                report_mismatch("response with no request outstanding");
                return;
            end
            exp_rsp = owed_rsp.pop_front();
            if (hit !== exp_rsp.hit)
                report_mismatch($sformatf("hit %b, want %b", hit, exp_rsp.hit));
            if (idx !== exp_rsp.line_index)
                report_mismatch($sformatf("line_index %0d, want %0d", idx,
                                          exp_rsp.line_index));
            if (d !== exp_rsp.data_out)
                report_mismatch($sformatf("data_out %h, want %h", d, exp_rsp.data_out));
            if (vwv !== exp_rsp.victim_was_valid)
                report_mismatch($sformatf("victim_was_valid %b, want %b", vwv,
                                          exp_rsp.victim_was_valid));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   req_idle_pct;
    int   rsp_idle_pct;
    int   rsp_hold;
    int   stall_cycles;
    key_t key_pool [12];

    lru_cache_scoreboard sb;

    falru_req_if req_ch ();
    falru_rsp_if rsp_ch ();

    fully_associative_lru_cache u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(input req_type_t kind, input key_t k, input data_t d);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.key      <= k;
        req_ch.data_in  <= d;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic run_directed();
        send_item(REQ_LOOKUP, '0, '1);
        send_item(REQ_LOOKUP, '1, '0);
        send_item(REQ_INSERT, '0, '1);
        send_item(REQ_INSERT, '1, '0);
        send_item(REQ_LOOKUP, '0, '0);
        send_item(REQ_LOOKUP, '1, '1);
        send_item(REQ_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        // second copy of an existing key
        send_item(REQ_INSERT, '0, 64'h0123_4567_89AB_CDEF);
        send_item(REQ_LOOKUP, '0, '0);
        send_item(REQ_INSERT, 64'h8000_0000_0000_0000, 64'h1);
        send_item(REQ_INSERT, 64'h1, 64'h8000_0000_0000_0000);
        send_item(REQ_INSERT, 64'hDEAD_BEEF_0000_FFFF, 64'hFFFF_0000_BEEF_DEAD);
        // cache full, evictions start
        send_item(REQ_INSERT, 64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE);
        send_item(REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, '1);
        send_item(REQ_LOOKUP, '1, '0);
        send_item(REQ_LOOKUP, 64'h5555_5555_5555_5555, '0);
        send_item(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, '0);
        send_item(REQ_LOOKUP, 64'h8000_0000_0000_0000, '1);
        send_item(REQ_LOOKUP, '0, '0);
        send_item(REQ_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, '0);
    endtask

    task automatic run_random(input int count);
        req_type_t kind;
        key_t      k;
        int        sent;
        sent = 0;
        while (sent < count)
        begin
            kind = ($urandom_range(99) < 40) ? REQ_INSERT : REQ_LOOKUP;
            k    = ($urandom_range(99) < 82) ? key_pool[$urandom_range(11)] : rand_word();
            send_item(kind, k, rand_word());
            sent++;
            // lookup straight after an insert of the same key
            if (kind == REQ_INSERT && $urandom_range(99) < 20)
            begin
                send_item(REQ_LOOKUP, k, rand_word());
                sent++;
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (rsp_hold > 0)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_hold = rsp_hold - 1;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            sb.note_request(req_type_t'(req_ch.req_type), key_t'(req_ch.key),
                            req_ch.data_in);
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.hit, rsp_ch.line_index, rsp_ch.data_out,
                              rsp_ch.victim_was_valid);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        sb              = new();
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = 1'b0;
        req_ch.key      = '0;
        req_ch.data_in  = '0;
        rsp_ch.ready    = 1'b0;
        rsp_hold        = 0;
        stall_cycles    = 0;
        req_idle_pct    = 18;
        rsp_idle_pct    = 54;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 12; i++)
            key_pool[i] = rand_word();
        // keys one bit apart
        key_pool[3] = key_pool[2] ^ 64'h1;
        key_pool[5] = key_pool[4] ^ 64'h8000_0000_0000_0000;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        run_random(360);
        wait_drained();

        req_idle_pct = 54;
        rsp_idle_pct = 18;
        run_random(380);
        wait_drained();

        req_idle_pct = 0;
        rsp_idle_pct = 0;
        rsp_hold     = 200;
        run_random(380);
        wait_drained();

        repeat (8) @(posedge clk);
        if (sb.err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
